// File: hw/rtl/ezr_pkg.sv
// Package for the ZXY Euler angle to rotation matrix pipeline.
// Holds angle and Q1.14 constants, field types and the sine series divisors.
// No dependencies.
package ezr_pkg;

	localparam int ANG_W = 16;          // input angle width, 1/64 degree
	localparam int RES_W = 16;          // Q1.14 result width
	localparam int RED_W = 15;          // reduced angle, [0, FULL_TURN)
	localparam int POS_W = 13;          // position inside a quarter turn, [0, QUARTER_TURN]
	localparam int MAG_W = 15;          // table entry magnitude, [0, ONE_Q14]

	localparam int FULL_TURN    = 23040;
	localparam int QUARTER_TURN = 5760;
	localparam int ONE_Q14      = 16384;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// (2n)(2n+1) for the Taylor terms n = 1..12 of the table builder
	localparam int SERIES_TERMS = 12;
	localparam int SERIES_DIV [1:SERIES_TERMS] = '{6, 20, 42, 72, 110, 156,
		210, 272, 342, 420, 506, 600};

	typedef logic signed [ANG_W-1:0] angle_t;
	typedef logic signed [RES_W-1:0] q14_t;
	typedef logic [RED_W-1:0]        red_t;
	typedef logic [POS_W-1:0]        pos_t;
	typedef logic [MAG_W-1:0]        mag_t;
	typedef logic [1:0]              quad_t;

endpackage

// File: hw/rtl/euler_zxy_to_rotation_matrix_top.sv
// ZXY Euler angles to 3x3 rotation matrix, eight-stage streaming pipeline.
// Depends on ezr_pkg for constants and types; the sine table is built at elaboration.
//
// Channel   Dir  Word                                   Handshake
// s_*       in   angle_x, angle_y, angle_z (3 x 16b)    tvalid/tready, accept on both high
// m_*       out  nine Q1.14 matrix entries (9 x 16b)    tvalid/tready, accept on both high
//
// One word enters every cycle while s_tready is high. The pipeline depth is
// set by the chain reduce, quadrant split, index scaling, reciprocal multiply,
// table read, pair products, triple products and the final round/add/saturate,
// one stage each.
// Reset (arst_n low) clears only the stage valid bits; payload registers float.
// Each stage advances when it is empty or the stage after it advances, so a
// stall on m_tready fills bubbles first and s_tready drops only once every
// stage holds a word. Nothing is dropped or repeated.
module euler_zxy_to_rotation_matrix_top
	import ezr_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	// s_tdata, low bit up: angle_x[15:0], angle_y[31:16], angle_z[47:32]
	input  logic [47:0]  s_tdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// m_tdata, low bit up: m_r0_c0, m_r1_c0, m_r2_c0, m_r0_c1, m_r1_c1,
	// m_r2_c1, m_r0_c2, m_r1_c2, m_r2_c2, 16 bits each
	output logic [143:0] m_tdata,
	output logic         m_tvalid,
	input  logic         m_tready
);

	// ------------------------------------------------------------------
	// Derived widths and the constant divider by QUARTER_TURN
	// ------------------------------------------------------------------
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
	// numerator p*DEPTH + QUARTER_TURN/2, p up to QUARTER_TURN
	localparam int NUM_W = $clog2(QUARTER_TURN * SINE_TABLE_DEPTH + QUARTER_TURN / 2 + 1);
	// shift wide enough that the rounded-up reciprocal gives an exact quotient
	localparam int RCP_SH = NUM_W + POS_W;
	localparam longint unsigned RCP_VAL =
		((64'd1 << RCP_SH) + QUARTER_TURN - 1) / QUARTER_TURN;
	localparam int RCP_W = $clog2(RCP_VAL + 1);
	localparam int PRD_W = NUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP_K = RCP_W'(RCP_VAL);

	localparam logic signed [17:0] FULL_S  = 18'(FULL_TURN);
	localparam logic signed [17:0] NFULL_S = -18'(FULL_TURN);
	localparam red_t Q1_BASE = RED_W'(QUARTER_TURN);
	localparam red_t Q2_BASE = RED_W'(2 * QUARTER_TURN);
	localparam red_t Q3_BASE = RED_W'(3 * QUARTER_TURN);
	localparam pos_t QT_POS  = POS_W'(QUARTER_TURN);

	// ------------------------------------------------------------------
	// Quarter-wave sine table, entry k = round(16384 * sin(90deg * k / depth))
	// ------------------------------------------------------------------
	function automatic mag_t sine_entry(input int k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint s;
		longint v;
		x = (HALF_PI_Q30 * longint'(k) + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		t = x;
		s = longint'(x);
		for (int n = 1; n <= SERIES_TERMS; n++) begin
			t = ((t * x2) >> 30) / SERIES_DIV[n];
			if (n % 2 == 1) begin
				s = s - longint'(t);
			end else begin
				s = s + longint'(t);
			end
		end
		if (s < 0) begin
			s = 0;
		end
		v = (s + 32768) >>> 16;
		if (v > ONE_Q14) begin
			v = ONE_Q14;
		end
		return v[MAG_W-1:0];
	endfunction

	mag_t sin_tbl [0:SINE_TABLE_DEPTH];

	for (genvar gk = 0; gk <= SINE_TABLE_DEPTH; gk++) begin : g_tbl
		localparam mag_t ENTRY = sine_entry(gk);
		assign sin_tbl[gk] = ENTRY;
	end

	// ------------------------------------------------------------------
	// Arithmetic helpers
	// ------------------------------------------------------------------
	// round a Q2.28 product to Q1.14, halves up (floor of v + half)
	function automatic q14_t rnd2(input logic signed [31:0] v);
		logic signed [31:0] t;
		t = v + 32'sd8192;
		return t[29:14];
	endfunction

	// round a Q3.42 triple product to Q1.14, halves up
	function automatic q14_t rnd3(input logic signed [47:0] v);
		logic signed [47:0] t;
		t = v + 48'sd134217728;
		return t[43:28];
	endfunction

	function automatic q14_t sat(input logic signed [17:0] v);
		if (v > 18'sd16384) begin
			return 16'sd16384;
		end else if (v < -18'sd16384) begin
			return -16'sd16384;
		end
		return v[15:0];
	endfunction

	function automatic q14_t add_sat(input q14_t a, input q14_t b);
		logic signed [17:0] ae;
		logic signed [17:0] be;
		ae = {{2{a[15]}}, a};
		be = {{2{b[15]}}, b};
		return sat(ae + be);
	endfunction

	function automatic q14_t sub_sat(input q14_t a, input q14_t b);
		logic signed [17:0] ae;
		logic signed [17:0] be;
		ae = {{2{a[15]}}, a};
		be = {{2{b[15]}}, b};
		return sat(ae - be);
	endfunction

	// ------------------------------------------------------------------
	// Stage valids and the advance chain
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;

	// a stage loads when it is empty or its word moves on this cycle
	assign en_s8 = !v_s8 || m_tready;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign s_tready = en_s1;
	assign m_tvalid = v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: reduce each angle modulo a full turn. Index 0 = x, 1 = y, 2 = z.
	// ------------------------------------------------------------------
	red_t r_s1 [3];
	red_t r_nx [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [17:0] ae;
			logic signed [17:0] rr;
			ae = 18'(angle_t'(s_tdata[ANG_W*k +: ANG_W]));
			if (ae < NFULL_S) begin
				rr = ae + FULL_S + FULL_S;
			end else if (ae < 18'sd0) begin
				rr = ae + FULL_S;
			end else if (ae >= FULL_S) begin
				rr = ae - FULL_S;
			end else begin
				rr = ae;
			end
			r_nx[k] = rr[RED_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) r_s1 <= r_nx;
	end

	// ------------------------------------------------------------------
	// Stage 2: split into quadrant and position, plus the mirrored position
	// ------------------------------------------------------------------
	quad_t q_s2  [3];
	pos_t  pa_s2 [3];
	pos_t  pb_s2 [3];
	quad_t q_nx2  [3];
	pos_t  pa_nx2 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (r_s1[k] >= Q3_BASE) begin
				q_nx2[k]  = 2'd3;
				pa_nx2[k] = POS_W'(r_s1[k] - Q3_BASE);
			end else if (r_s1[k] >= Q2_BASE) begin
				q_nx2[k]  = 2'd2;
				pa_nx2[k] = POS_W'(r_s1[k] - Q2_BASE);
			end else if (r_s1[k] >= Q1_BASE) begin
				q_nx2[k]  = 2'd1;
				pa_nx2[k] = POS_W'(r_s1[k] - Q1_BASE);
			end else begin
				q_nx2[k]  = 2'd0;
				pa_nx2[k] = POS_W'(r_s1[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int k = 0; k < 3; k++) begin
				q_s2[k]  <= q_nx2[k];
				pa_s2[k] <= pa_nx2[k];
				pb_s2[k] <= QT_POS - pa_nx2[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: scale positions to the table depth, add half a quarter turn
	// ------------------------------------------------------------------
	quad_t            q_s3  [3];
	logic [NUM_W-1:0] na_s3 [3];
	logic [NUM_W-1:0] nb_s3 [3];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int k = 0; k < 3; k++) begin
				q_s3[k]  <= q_s2[k];
				na_s3[k] <= NUM_W'(int'(pa_s2[k]) * SINE_TABLE_DEPTH + QUARTER_TURN / 2);
				nb_s3[k] <= NUM_W'(int'(pb_s2[k]) * SINE_TABLE_DEPTH + QUARTER_TURN / 2);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: table index = numerator / QUARTER_TURN via exact reciprocal
	// ------------------------------------------------------------------
	quad_t            q_s4  [3];
	logic [IDX_W-1:0] ia_s4 [3];
	logic [IDX_W-1:0] ib_s4 [3];
	logic [PRD_W-1:0] pra   [3];
	logic [PRD_W-1:0] prb   [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pra[k] = PRD_W'(na_s3[k]) * PRD_W'(RCP_K);
			prb[k] = PRD_W'(nb_s3[k]) * PRD_W'(RCP_K);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int k = 0; k < 3; k++) begin
				q_s4[k]  <= q_s3[k];
				ia_s4[k] <= pra[k][RCP_SH +: IDX_W];
				ib_s4[k] <= prb[k][RCP_SH +: IDX_W];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: table read and quadrant signs. Cosine sits one quadrant ahead
	// with the same position, so it takes the opposite mirror of the sine.
	// ------------------------------------------------------------------
	q14_t sin_s5 [3];
	q14_t cos_s5 [3];
	mag_t sa_mag [3];
	mag_t sb_mag [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sa_mag[k] = sin_tbl[ia_s4[k]];
			sb_mag[k] = sin_tbl[ib_s4[k]];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [RES_W-1:0] sm;
				logic signed [RES_W-1:0] cm;
				sm = q_s4[k][0] ? q14_t'({1'b0, sb_mag[k]}) : q14_t'({1'b0, sa_mag[k]});
				cm = q_s4[k][0] ? q14_t'({1'b0, sa_mag[k]}) : q14_t'({1'b0, sb_mag[k]});
				sin_s5[k] <= q_s4[k][1] ? -sm : sm;
				cos_s5[k] <= (q_s4[k][1] ^ q_s4[k][0]) ? -cm : cm;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: pair products (exact, Q2.28)
	// ------------------------------------------------------------------
	logic signed [31:0] cycz_s6, cxsy_s6, cxsz_s6, cxcz_s6, cxcy_s6;
	logic signed [31:0] cysz_s6, czsy_s6, sysz_s6;
	logic signed [31:0] sxsy_s6, sxsz_s6, sxcz_s6;
	q14_t               cy_s6, cz_s6, sz_s6, nsx_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			cycz_s6 <= cos_s5[1] * cos_s5[2];
			cxsy_s6 <= cos_s5[0] * sin_s5[1];
			cxsz_s6 <= cos_s5[0] * sin_s5[2];
			cxcz_s6 <= cos_s5[0] * cos_s5[2];
			cxcy_s6 <= cos_s5[0] * cos_s5[1];
			cysz_s6 <= cos_s5[1] * sin_s5[2];
			czsy_s6 <= cos_s5[2] * sin_s5[1];
			sysz_s6 <= sin_s5[1] * sin_s5[2];
			sxsy_s6 <= sin_s5[0] * sin_s5[1];
			sxsz_s6 <= sin_s5[0] * sin_s5[2];
			sxcz_s6 <= sin_s5[0] * cos_s5[2];
			cy_s6   <= cos_s5[1];
			cz_s6   <= cos_s5[2];
			sz_s6   <= sin_s5[2];
			nsx_s6  <= -sin_s5[0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: triple products (exact, Q3.42) and rounded pair terms
	// ------------------------------------------------------------------
	logic signed [47:0] t00_s7, t10_s7, t02_s7, t12_s7;
	q14_t               cycz_s7, cysz_s7, czsy_s7, sysz_s7;
	q14_t               r20_s7, r01_s7, r11_s7, r21_s7, r22_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			t00_s7  <= sxsy_s6 * sz_s6;
			t10_s7  <= sxsy_s6 * cz_s6;
			t02_s7  <= sxsz_s6 * cy_s6;
			t12_s7  <= sxcz_s6 * cy_s6;
			cycz_s7 <= rnd2(cycz_s6);
			cysz_s7 <= rnd2(cysz_s6);
			czsy_s7 <= rnd2(czsy_s6);
			sysz_s7 <= rnd2(sysz_s6);
			r20_s7  <= rnd2(cxsy_s6);
			r01_s7  <= rnd2(cxsz_s6);
			r11_s7  <= rnd2(cxcz_s6);
			r21_s7  <= nsx_s6;
			r22_s7  <= rnd2(cxcy_s6);
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: round triples, combine and saturate into the output word
	// ------------------------------------------------------------------
	q14_t r00_s8, r10_s8, r20_s8, r01_s8, r11_s8, r21_s8, r02_s8, r12_s8, r22_s8;

	always_ff @(posedge clk) begin
		if (en_s8) begin
			r00_s8 <= add_sat(cycz_s7, rnd3(t00_s7));
			r10_s8 <= sub_sat(rnd3(t10_s7), cysz_s7);
			r20_s8 <= r20_s7;
			r01_s8 <= r01_s7;
			r11_s8 <= r11_s7;
			r21_s8 <= r21_s7;
			r02_s8 <= sub_sat(rnd3(t02_s7), czsy_s7);
			r12_s8 <= add_sat(rnd3(t12_s7), sysz_s7);
			r22_s8 <= r22_s7;
		end
	end

	assign m_tdata = {r22_s8, r12_s8, r02_s8, r21_s8, r11_s8, r01_s8, r20_s8, r10_s8, r00_s8};

endmodule
